[rtl/npc_pkg.sv]
// npc_pkg: shared types, constants and the squared channel distance function
// for the nearest palette color search; used by every rtl file of the block
`default_nettype none

package npc_pkg;

   // table depth and field widths
   localparam int ENTRIES = 256;
   localparam int IDX_W   = 8;
   localparam int CNT_W   = IDX_W + 1;
   localparam int CHAN_W  = 8;
   localparam int SQ_W    = 2 * CHAN_W;
   localparam int DIST_W  = SQ_W + 2;
   localparam int OFS_W   = 8;
   localparam int NUM_W   = 9;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_OFFSET = 2'd1;
   localparam logic [OFS_W-1:0]     INDEX_OFFSET_RST = 8'd16;

   // request kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } color_type;

   // search token that walks down the cell chain
   typedef struct packed {
      logic              valid;
      logic              found;
      logic [IDX_W-1:0]  idx;
      logic [DIST_W-1:0] cost;
   } wave_type;

   function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
      logic [CHAN_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

endpackage

`default_nettype wire

[rtl/npc_cell.sv]
// npc_cell: one palette cell, holds one entry, keeps its registered distance
// to the current pixel and updates the passing search token; uses npc_pkg
`default_nettype none

module npc_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  npc_pkg::color_type        wr_color,
   input  npc_pkg::color_type        pixel,
   input  logic [npc_pkg::CNT_W-1:0] count,
   input  logic [npc_pkg::IDX_W-1:0] cell_idx,
   input  npc_pkg::wave_type         wave_in,
   output npc_pkg::wave_type         wave_out
);
   import npc_pkg::*;

   color_type         entry_ff, entry_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   wave_type          wave_ff, wave_in_nx;
   logic              active;
   logic              take;

   always_comb begin
      entry_in = wr_en ? wr_color : entry_ff;
      dist_in  = DIST_W'(sq_diff(pixel.red, entry_ff.red))
               + DIST_W'(sq_diff(pixel.green, entry_ff.green))
               + DIST_W'(sq_diff(pixel.blue, entry_ff.blue));
   end

   // cells at or beyond the palette size just pass the token on
   assign active = CNT_W'(cell_idx) < count;
   assign take   = wave_in.valid && active && (!wave_in.found || (dist_ff < wave_in.cost));

   always_comb begin
      wave_in_nx = wave_in;
      if (take) begin
         wave_in_nx.found = 1'b1;
         wave_in_nx.idx   = cell_idx;
         wave_in_nx.cost  = dist_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      dist_ff  <= dist_in;
      if (reset) begin
         wave_ff <= '0;
      end else begin
         wave_ff <= wave_in_nx;
      end
   end

   assign wave_out = wave_ff;

endmodule

`default_nettype wire

[rtl/nearest_palette_color.sv]
// nearest_palette_color: palette quantizer, nearest entry by squared rgb
// distance, built as a chain of npc_cell instances; uses npc_pkg
`default_nettype none

//  channel | ports                          | direction | moves
//  --------+--------------------------------+-----------+---------------------------
//  req     | req_valid/ready, kind..blue    | in        | load or query request
//  rsp     | rsp_valid/ready, index, number | out       | one result per query
//  csr     | csr_wr_en, index, wdata        | in        | palette size, index offset
//
//  a load request writes its cell at once when it is taken
//  a query holds off the next request from acceptance until its result moves
//  to the output register; the search token crosses the chain one cell per cycle
//  the result is held in an output register, so a stalled rsp side does not
//  stop the next request from being accepted, only the query after it
//  reset sets control and csr registers; palette entries and payload are not reset

module nearest_palette_color (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [npc_pkg::IDX_W-1:0]      req_entry_index,
   input  logic [npc_pkg::CHAN_W-1:0]     req_red,
   input  logic [npc_pkg::CHAN_W-1:0]     req_green,
   input  logic [npc_pkg::CHAN_W-1:0]     req_blue,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [npc_pkg::IDX_W-1:0]      rsp_palette_index,
   output logic [npc_pkg::NUM_W-1:0]      rsp_color_number,
   // configuration writes
   input  logic                           csr_wr_en,
   input  logic [npc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [npc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import npc_pkg::*;

   // configuration registers
   logic [CNT_W-1:0] palette_size_ff, palette_size_in;
   logic [OFS_W-1:0] index_offset_ff, index_offset_in;

   // control
   logic busy_ff, busy_in;           // a query is in the chain or waiting
   logic inject_ff, inject_in;       // pixel latched, distances settle next cycle
   logic pend_valid_ff, pend_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   // payload
   color_type        pixel_ff, pixel_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [NUM_W-1:0] rsp_num_ff, rsp_num_in;

   wave_type  chain [ENTRIES+1];
   wave_type  wave0_ff, wave0_in;
   color_type req_color;
   logic      req_fire;
   logic      load_fire;
   logic      query_fire;
   logic      move;

   assign req_color  = '{red: req_red, green: req_green, blue: req_blue};
   assign req_ready  = !busy_ff;
   assign req_fire   = req_valid && req_ready;
   assign load_fire  = req_fire && (req_kind == KIND_LOAD);
   assign query_fire = req_fire && (req_kind == KIND_QUERY);

   // pending result goes to the output register once it is free
   assign move = pend_valid_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      palette_size_in = palette_size_ff;
      index_offset_in = index_offset_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PALETTE_SIZE: palette_size_in = csr_wdata[CNT_W-1:0];
            CSR_INDEX_OFFSET: index_offset_in = csr_wdata[OFS_W-1:0];
            default: ;  // unknown register, write dropped
         endcase
      end
   end

   always_comb begin
      pixel_in  = query_fire ? req_color : pixel_ff;
      inject_in = query_fire;
      // token starts empty; the first active cell always takes it
      wave0_in       = '0;
      wave0_in.valid = inject_ff;

      busy_in = busy_ff;
      if (query_fire) begin
         busy_in = 1'b1;
      end else if (move) begin
         busy_in = 1'b0;
      end

      // chain tail: an empty palette leaves found low and index zero
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      if (chain[ENTRIES].valid) begin
         pend_valid_in = 1'b1;
         pend_idx_in   = chain[ENTRIES].found ? chain[ENTRIES].idx : '0;
      end else if (move) begin
         pend_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_num_in   = rsp_num_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = pend_idx_ff;
         rsp_num_in   = NUM_W'(pend_idx_ff) + NUM_W'(index_offset_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff    <= pixel_in;
      pend_idx_ff <= pend_idx_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_num_ff  <= rsp_num_in;
      if (reset) begin
         palette_size_ff <= '0;
         index_offset_ff <= INDEX_OFFSET_RST;
         busy_ff         <= 1'b0;
         inject_ff       <= 1'b0;
         wave0_ff        <= '0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         palette_size_ff <= palette_size_in;
         index_offset_ff <= index_offset_in;
         busy_ff         <= busy_in;
         inject_ff       <= inject_in;
         wave0_ff        <= wave0_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign chain[0] = wave0_ff;

   // the cell row: cell g holds palette entry g
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      npc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (load_fire && (req_entry_index == IDX_W'(g))),
         .wr_color (req_color),
         .pixel    (pixel_ff),
         .count    (palette_size_ff),
         .cell_idx (IDX_W'(g)),
         .wave_in  (chain[g]),
         .wave_out (chain[g+1])
      );
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_palette_index = rsp_idx_ff;
   assign rsp_color_number  = rsp_num_ff;

endmodule

`default_nettype wire

[rtl/npc_checker.sv]
// npc_checker: port level checks for nearest_palette_color and the bind that
// attaches them; uses npc_pkg
`default_nettype none

module npc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_kind,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [npc_pkg::IDX_W-1:0]      rsp_palette_index,
   input logic [npc_pkg::NUM_W-1:0]      rsp_color_number,
   input logic                           csr_wr_en,
   input logic [npc_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [npc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import npc_pkg::*;

   // mirror of the palette size register
   logic [CNT_W-1:0] size_ff, size_in;

   always_comb begin
      size_in = size_ff;
      if (csr_wr_en && (csr_index == CSR_PALETTE_SIZE)) begin
         size_in = csr_wdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
      end else begin
         size_ff <= size_in;
      end
   end

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_palette_index) && $stable(rsp_color_number))
      else $error("stalled result changed");

   // a query occupies the search chain
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_QUERY) |=> !req_ready)
      else $error("request taken while a query is searching");

   // a load does not block the next request
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_LOAD) |=> req_ready)
      else $error("load blocked the request channel");

   // the winner lies inside the searched palette
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((size_ff == '0) && (rsp_palette_index == '0))
                 || (CNT_W'(rsp_palette_index) < size_ff))
      else $error("result index outside the palette");

endmodule

bind nearest_palette_color npc_checker u_npc_checker (.*);

`default_nettype wire

[test/tb_nearest_palette_color.sv]
// tb_nearest_palette_color: self-checking bench for the palette quantizer; a scoreboard
// class keeps its own palette copy and registers and predicts every query result
// depends on npc_pkg and the nearest_palette_color rtl

module tb_nearest_palette_color;
   import npc_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 1850;
   // the quiet time covers one full search of the chain
   localparam int SETTLE_CYCLES = ENTRIES + 8;
   // long enough for one result in the output register and a second search finished behind it
   localparam int LONG_HOLD = 4 * (ENTRIES + 4);
   // every request a query, every result and gap at its worst, then taken a few times over
   localparam longint LIMIT_CYCLES = 2_500_000;
   localparam int REPORT_CAP = 100;

   // register indexes beyond the two defined ones, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic             kind;
      logic [IDX_W-1:0] slot;
      color_type        color;
   } palette_req_type;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic [NUM_W-1:0] number;
   } palette_rsp_type;

   // palette copy, register copy and the queue of predicted query results
   class palette_tracker;
      color_type       entries [ENTRIES];
      bit              written [ENTRIES];
      int unsigned     size_reg;
      int unsigned     offset_reg;
      palette_rsp_type pending_q [$];
      int unsigned     errors;

      function new();
         size_reg   = 0;
         offset_reg = INDEX_OFFSET_RST;
         errors     = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_PALETTE_SIZE) begin
            size_reg = data;
         end else if (idx == CSR_INDEX_OFFSET) begin
            offset_reg = data[OFS_W-1:0];
         end
      endfunction

      function int unsigned distance(color_type a, color_type b);
         int dr, dg, db;
         dr = int'(a.red) - int'(b.red);
         dg = int'(a.green) - int'(b.green);
         db = int'(a.blue) - int'(b.blue);
         return dr * dr + dg * dg + db * db;
      endfunction

      // strict less-than keeps the lowest index on ties
      function palette_rsp_type nearest_entry(color_type pixel);
         palette_rsp_type r;
         int unsigned     span, best, best_dist, d;
         span      = (size_reg > ENTRIES) ? ENTRIES : size_reg;
         best      = 0;
         best_dist = 32'h7FFF_FFFF;
         for (int unsigned i = 0; i < span; i++) begin
            d = distance(pixel, entries[i]);
            if (d < best_dist) begin
               best_dist = d;
               best      = i;
            end
         end
         r.index  = best[IDX_W-1:0];
         r.number = NUM_W'(best + offset_reg);
         return r;
      endfunction

      function void note_request(palette_req_type r);
         if (r.kind == KIND_LOAD) begin
            entries[r.slot] = r.color;
            written[r.slot] = 1'b1;
         end else begin
            pending_q.push_back(nearest_entry(r.color));
         end
      endfunction

      function void check_result(logic [IDX_W-1:0] idx, logic [NUM_W-1:0] num);
         palette_rsp_type want;
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("%0t: unexpected result, expected none, actual index %0d number %0d",
                        $time, idx, num);
            return;
         end
         want = pending_q.pop_front();
         if (idx !== want.index) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("%0t: palette_index mismatch, expected %0d, actual %0d",
                        $time, want.index, idx);
         end
         if (num !== want.number) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("%0t: color_number mismatch, expected %0d, actual %0d",
                        $time, want.number, num);
         end
      endfunction

      function int unsigned waiting();
         return pending_q.size();
      endfunction

      // entries 0 .. n-1 all loaded: the widest search a query may use
      function int unsigned loaded_prefix();
         int unsigned n;
         n = 0;
         while (n < ENTRIES && written[n]) n++;
         return n;
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_kind;
   logic [IDX_W-1:0]      req_entry_index;
   logic [CHAN_W-1:0]     req_red;
   logic [CHAN_W-1:0]     req_green;
   logic [CHAN_W-1:0]     req_blue;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [IDX_W-1:0]      rsp_palette_index;
   logic [NUM_W-1:0]      rsp_color_number;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   palette_tracker tracker = new();
   // set by the stimulus once per chosen phase, consumed by the result side
   bit             long_hold_asked = 1'b0;

   nearest_palette_color u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_entry_index   (req_entry_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_palette_index (rsp_palette_index),
      .rsp_color_number  (rsp_color_number),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // drive a request at the falling edge and hold it until a rising edge takes it
   task automatic offer(input palette_req_type r);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_kind        <= r.kind;
      req_entry_index <= r.slot;
      req_red         <= r.color.red;
      req_green       <= r.color.green;
      req_blue        <= r.color.blue;
      do @(posedge clock); while (req_ready !== 1'b1);
      tracker.note_request(r);
   endtask

   // gap with valid low, its length given by n
   task automatic pause_sender(input int unsigned n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // sender stops until every predicted result has come back
   task automatic wait_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.waiting() != 0) @(posedge clock);
   endtask

   // loads give no result, so let one more search time pass before touching registers
   task automatic wait_idle();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      tracker.write_register(idx, data);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_entry(input logic [IDX_W-1:0] slot, input logic [CHAN_W-1:0] r,
                             input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
      palette_req_type item;
      item.kind  = KIND_LOAD;
      item.slot  = slot;
      item.color = {r, g, b};
      offer(item);
   endtask

   // entry_index of a query is don't-care, so it carries noise
   task automatic query_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b);
      palette_req_type item;
      item.kind  = KIND_QUERY;
      item.slot  = IDX_W'($urandom);
      item.color = {r, g, b};
      offer(item);
   endtask

   // black, mid gray or full: gives exact hits, ties and channel extremes
   function automatic logic [CHAN_W-1:0] coarse_level();
      case ($urandom_range(0, 2))
         0: begin
            return 8'd0;
         end
         1: begin
            return 8'd128;
         end
         default: begin
            return 8'd255;
         end
      endcase
   endfunction

   // result side: stall pattern drawn at random from four modes, plus one-off long holds
   initial begin
      int unsigned tick, hold_left, mode;
      tick      = 0;
      hold_left = 0;
      mode      = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (tick % 97 == 0) mode = $urandom_range(0, 3);
         if (long_hold_asked) begin
            long_hold_asked = 1'b0;
            hold_left       = LONG_HOLD;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            case (mode)
               0: begin
                  rsp_ready <= 1'b1;
               end
               1: begin
                  rsp_ready <= (tick % 4 != 0);
               end
               2: begin
                  rsp_ready <= 1'($urandom_range(0, 1));
               end
               default: begin
                  rsp_ready <= (tick % 5 == 0);
               end
            endcase
         end
      end
   end

   // results are taken at the rising edge where valid and ready meet
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         tracker.check_result(rsp_palette_index, rsp_color_number);
      end
   end

   initial begin
      palette_req_type       item;
      int unsigned           sent, prefix, span, burst_left, phase, roll;
      bit                    steady;
      logic [CSR_DATA_W-1:0] size_val, offset_val;

      req_valid       <= 1'b0;
      req_kind        <= KIND_LOAD;
      req_entry_index <= '0;
      req_red         <= '0;
      req_green       <= '0;
      req_blue        <= '0;
      csr_wr_en       <= 1'b0;
      csr_index       <= CSR_PALETTE_SIZE;
      csr_wdata       <= '0;
      reset           <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty palette straight out of reset: index 0, number is the reset offset
      query_pixel(8'd0, 8'd0, 8'd0);
      query_pixel(8'd255, 8'd255, 8'd255);

      // black, white, the primaries, a second pure red behind the first, and the top slot
      load_entry(8'd0, 8'd0, 8'd0, 8'd0);
      load_entry(8'd1, 8'd255, 8'd255, 8'd255);
      load_entry(8'd2, 8'd255, 8'd0, 8'd0);
      load_entry(8'd3, 8'd0, 8'd255, 8'd0);
      load_entry(8'd4, 8'd0, 8'd0, 8'd255);
      load_entry(8'd5, 8'd255, 8'd0, 8'd0);
      load_entry(8'd255, 8'd128, 8'd128, 8'd128);
      wait_idle();

      // six entries, largest offset: numbers run up toward the top of their range
      write_register(CSR_PALETTE_SIZE, 9'd6);
      write_register(CSR_INDEX_OFFSET, 9'd255);
      query_pixel(8'd255, 8'd0, 8'd0);      // exact hit, the later duplicate must lose
      query_pixel(8'd0, 8'd0, 8'd0);
      query_pixel(8'd255, 8'd255, 8'd255);
      query_pixel(8'd0, 8'd0, 8'd255);
      query_pixel(8'd128, 8'd128, 8'd0);    // same distance to red and to green
      query_pixel(8'd128, 8'd128, 8'd128);
      query_pixel(8'd200, 8'd10, 8'd90);
      wait_idle();

      // single entry, zero offset; writes to the spare indexes must not land anywhere
      write_register(CSR_PALETTE_SIZE, 9'd1);
      write_register(CSR_INDEX_OFFSET, 9'd0);
      write_register(CSR_SPARE_A, 9'h1FF);
      write_register(CSR_SPARE_B, 9'h0AA);
      query_pixel(8'd255, 8'd255, 8'd255);
      query_pixel(8'd17, 8'd34, 8'd51);
      wait_idle();

      // random phases: fresh registers each phase, search width never past loaded entries
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         prefix = tracker.loaded_prefix();
         case ($urandom_range(0, 5))
            0: begin
               size_val = 9'd0;
            end
            1: begin
               size_val = (prefix >= 1) ? 9'd1 : 9'd0;
            end
            2: begin
               size_val = CSR_DATA_W'(prefix);
            end
            3: begin
               // past the table depth the search saturates at all entries
               size_val = (prefix == ENTRIES) ? CSR_DATA_W'($urandom_range(ENTRIES + 1, 511))
                                              : CSR_DATA_W'(prefix);
            end
            4: begin
               size_val = (prefix == ENTRIES) ? 9'd511 : CSR_DATA_W'($urandom_range(0, prefix));
            end
            default: begin
               size_val = CSR_DATA_W'($urandom_range(0, prefix));
            end
         endcase
         // bit 8 of an offset write is noise and must be dropped
         case ($urandom_range(0, 3))
            0: begin
               offset_val = 9'd0;
            end
            1: begin
               offset_val = 9'd255;
            end
            2: begin
               offset_val = 9'h1FF;
            end
            default: begin
               offset_val = CSR_DATA_W'($urandom);
            end
         endcase
         write_register(CSR_PALETTE_SIZE, size_val);
         write_register(CSR_INDEX_OFFSET, offset_val);
         if ($urandom_range(0, 3) == 0) begin
            write_register($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                           CSR_DATA_W'($urandom));
         end

         span       = (size_val > ENTRIES) ? ENTRIES : size_val;
         steady     = ($urandom_range(0, 3) == 0);
         burst_left = $urandom_range(1, 16);
         // result side holds off while requests keep coming: the block must back up
         if (phase == 2 || phase == 13) long_hold_asked = 1'b1;

         repeat ($urandom_range(30, 120)) begin
            roll       = $urandom_range(0, 99);
            item.slot  = IDX_W'($urandom);
            item.color = 24'($urandom);
            if (roll < 30) begin
               item.kind = KIND_LOAD;
            end else if (roll < 60 && tracker.loaded_prefix() < ENTRIES) begin
               // grow the loaded prefix so later phases can search wider
               item.kind = KIND_LOAD;
               item.slot = IDX_W'(tracker.loaded_prefix());
            end else begin
               item.kind = KIND_QUERY;
            end

            roll = $urandom_range(0, 9);
            if (item.kind == KIND_LOAD) begin
               if (roll < 3) item.color = {coarse_level(), coarse_level(), coarse_level()};
            end else if (roll < 3 && span != 0) begin
               // exact copy of a searched entry, sometimes nudged by one step of red
               item.color = tracker.entries[$urandom_range(0, span - 1)];
               if (roll == 0) item.color.red = item.color.red + 8'd1;
            end else if (roll < 5) begin
               item.color = {coarse_level(), coarse_level(), coarse_level()};
            end

            offer(item);
            sent++;

            if ($urandom_range(0, 199) == 0) begin
               wait_results();
            end else if (!steady) begin
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  pause_sender($urandom_range(1, 8));
                  burst_left = $urandom_range(1, 16);
               end
            end
         end

         wait_idle();
         phase++;
      end

      if (tracker.errors == 0 && tracker.waiting() == 0) begin
         $display("nearest_palette_color verification clean");
      end else begin
         $display("nearest_palette_color verification failed");
      end
      $finish;
   end

   // hard stop in case the block hangs
   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("nearest_palette_color verification failed");
      $finish;
   end

endmodule
